/* src/smfir_pkg.sv */
// ----------------------------------------------------------------------------
// smfir_pkg
// Shared widths, register indexes, control structs and the mirror fold
// used by the symmetric FIR line filter.
// ----------------------------------------------------------------------------
package smfir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int HL_W     = 3;
    localparam int LEN_W    = 13;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_COEF = 4;
    localparam int PAIR_W   = SAMPLE_W + 1;
    localparam int PROD_W   = COEF_W + PAIR_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int FRAC_W   = 15;
    localparam int AGE_W    = 3;
    localparam int REL_W    = 4;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(16384);
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_LENGTH = 3'd0,
        CFG_LINE_LENGTH = 3'd1,
        CFG_COEF_CENTER = 3'd2,
        CFG_COEF_ONE    = 3'd3,
        CFG_COEF_TWO    = 3'd4,
        CFG_COEF_THREE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic line_end;
        logic burst_end;
    } t_meta;

    typedef struct packed {
        logic [AGE_W-1:0] lag;
        logic [AGE_W-1:0] pmin;
        t_meta            meta;
    } t_slot;

    // Reflect a distance behind the newest sample into 0..p, period 2p.
    function automatic logic [AGE_W-1:0] fold_age(input logic signed [REL_W-1:0] x,
                                                   input logic [AGE_W-1:0] p);
        int v;
        int pp;
        v  = int'(x);
        pp = int'(p);
        for (int i = 0; i < 4; i++) begin
            if (v < 0) v = -v;
            if (v > pp) v = 2 * pp - v;
        end
        if (pp == 0) v = 0;
        return AGE_W'(v);
    endfunction

endpackage

/* src/smfir_front.sv */
// ----------------------------------------------------------------------------
// smfir_front
// Sample window, line position tracking and per-transfer result sequencing.
// ----------------------------------------------------------------------------
module smfir_front #(
    parameter int MAX_LINE_LENGTH = 4096,
    parameter int MAX_HALF_LENGTH = 4,
    localparam int WIN   = 2 * MAX_HALF_LENGTH - 1,
    localparam int LAG_W = $clog2(MAX_HALF_LENGTH)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [smfir_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [smfir_pkg::LEN_W-1:0]           i_line_length,
    input  logic [LAG_W-1:0]                      i_taps,
    input  logic                                  i_free,
    output logic                                  o_issue,
    output smfir_pkg::t_slot                      o_slot,
    output logic signed [smfir_pkg::SAMPLE_W-1:0] o_win [WIN]
);

    localparam int POS_W = $clog2(MAX_LINE_LENGTH);
    localparam int CMP_W = ((POS_W > smfir_pkg::LEN_W) ? POS_W : smfir_pkg::LEN_W) + 1;
    localparam int CNT_W = $clog2(MAX_HALF_LENGTH + 1);

    logic signed [smfir_pkg::SAMPLE_W-1:0] r_win [WIN];
    logic [POS_W-1:0] r_pos, n_pos;
    logic [LAG_W-1:0] r_lag, n_lag;
    logic             r_s0_valid, n_s0_valid;
    logic [LAG_W-1:0] r_s0_lag, n_s0_lag;
    logic [CNT_W-1:0] r_s0_rem, n_s0_rem;
    logic             r_s0_last, n_s0_last;
    logic [smfir_pkg::AGE_W-1:0] r_s0_pmin, n_s0_pmin;

    logic [CMP_W-1:0] n_lim;
    logic             accept;
    logic             last;
    logic             fin;
    logic [CNT_W-1:0] d_c;
    logic [CNT_W-1:0] taps_c;
    logic [CNT_W-1:0] cnt;

    assign o_issue = r_s0_valid && i_free;
    assign fin     = o_issue && (r_s0_rem == CNT_W'(1));
    assign o_ready = !r_s0_valid || fin;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (i_line_length == '0) begin
            n_lim = CMP_W'(1);
        end else if (CMP_W'(i_line_length) > CMP_W'(MAX_LINE_LENGTH)) begin
            n_lim = CMP_W'(MAX_LINE_LENGTH);
        end else begin
            n_lim = CMP_W'(i_line_length);
        end
        last   = (CMP_W'(r_pos) + CMP_W'(1)) >= n_lim;
        d_c    = CNT_W'(r_lag);
        taps_c = CNT_W'(i_taps);
        if (last) begin
            cnt = d_c + CNT_W'(1);
        end else if (d_c >= taps_c) begin
            cnt = d_c - taps_c + CNT_W'(1);
        end else begin
            cnt = '0;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_lag      = r_lag;
        n_s0_valid = r_s0_valid;
        n_s0_lag   = r_s0_lag;
        n_s0_rem   = r_s0_rem;
        n_s0_last  = r_s0_last;
        n_s0_pmin  = r_s0_pmin;
        if (o_issue) begin
            n_s0_lag = r_s0_lag - LAG_W'(1);
            n_s0_rem = r_s0_rem - CNT_W'(1);
            if (fin) n_s0_valid = 1'b0;
        end
        if (accept) begin
            if (last) begin
                n_pos = '0;
                n_lag = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
                n_lag = LAG_W'(d_c - cnt + CNT_W'(1));
            end
            if (cnt != '0) begin
                n_s0_valid = 1'b1;
                n_s0_lag   = r_lag;
                n_s0_rem   = cnt;
                n_s0_last  = last;
                n_s0_pmin  = (r_pos > POS_W'(7)) ? smfir_pkg::AGE_W'(7)
                                                 : r_pos[smfir_pkg::AGE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_lag      <= '0;
            r_s0_valid <= 1'b0;
            r_s0_lag   <= '0;
            r_s0_rem   <= '0;
            r_s0_last  <= 1'b0;
            r_s0_pmin  <= '0;
        end else begin
            r_pos      <= n_pos;
            r_lag      <= n_lag;
            r_s0_valid <= n_s0_valid;
            r_s0_lag   <= n_s0_lag;
            r_s0_rem   <= n_s0_rem;
            r_s0_last  <= n_s0_last;
            r_s0_pmin  <= n_s0_pmin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win[0] <= i_sample;
            for (int d = 1; d < WIN; d++) begin
                r_win[d] <= r_win[d-1];
            end
        end
    end

    assign o_win              = r_win;
    assign o_slot.lag         = smfir_pkg::AGE_W'(r_s0_lag);
    assign o_slot.pmin        = r_s0_pmin;
    assign o_slot.meta.line_end  = r_s0_last && (r_s0_lag == '0);
    assign o_slot.meta.burst_end = (r_s0_rem == CNT_W'(1));

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_valid |-> (r_s0_rem != '0))
        else $error("pending burst with no results left");

    a_rem_in_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_valid |-> (r_s0_rem <= CNT_W'(r_s0_lag) + CNT_W'(1)))
        else $error("burst runs past newest position");

    a_flush_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_valid && r_s0_last && (r_s0_rem == CNT_W'(1))) |-> (r_s0_lag == '0))
        else $error("line flush does not end at last position");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> ((r_pos == '0) && (r_lag == '0)))
        else $error("position not cleared after line end");

endmodule

/* src/smfir_mac.sv */
// ----------------------------------------------------------------------------
// smfir_mac
// Mirror tap selection, symmetric pre-add and tap multiplies, registered.
// ----------------------------------------------------------------------------
module smfir_mac #(
    parameter int MAX_HALF_LENGTH = 4,
    localparam int WIN   = 2 * MAX_HALF_LENGTH - 1,
    localparam int LAG_W = $clog2(MAX_HALF_LENGTH)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  smfir_pkg::t_slot                      i_slot,
    input  logic signed [smfir_pkg::SAMPLE_W-1:0] i_win [WIN],
    input  logic [LAG_W-1:0]                      i_taps,
    input  logic signed [smfir_pkg::COEF_W-1:0]   i_coef [smfir_pkg::NUM_COEF],
    input  logic                                  i_next_free,
    output logic                                  o_free,
    output logic                                  o_valid,
    output logic signed [smfir_pkg::PROD_W-1:0]   o_prod [MAX_HALF_LENGTH],
    output smfir_pkg::t_meta                      o_meta
);

    localparam int IDX_W = $clog2(WIN);

    logic r_valid;
    logic signed [smfir_pkg::PROD_W-1:0] r_prod [MAX_HALF_LENGTH];
    logic signed [smfir_pkg::PROD_W-1:0] n_prod [MAX_HALF_LENGTH];
    smfir_pkg::t_meta r_meta;

    assign o_free = !r_valid || i_next_free;

    for (genvar k = 0; k < MAX_HALF_LENGTH; k++) begin : g_tap
        logic signed [smfir_pkg::REL_W-1:0]  x_l;
        logic [smfir_pkg::AGE_W-1:0]         age_l;
        logic signed [smfir_pkg::PAIR_W-1:0] pair;
        logic signed [smfir_pkg::COEF_W-1:0] coef;

        assign x_l   = smfir_pkg::REL_W'(i_slot.lag) + smfir_pkg::REL_W'(k);
        assign age_l = smfir_pkg::fold_age(x_l, i_slot.pmin);

        if (k == 0) begin : g_centre
            assign pair = smfir_pkg::PAIR_W'(i_win[age_l[IDX_W-1:0]]);
        end else begin : g_side
            logic signed [smfir_pkg::REL_W-1:0] x_r;
            logic [smfir_pkg::AGE_W-1:0]        age_r;

            assign x_r   = smfir_pkg::REL_W'(i_slot.lag) - smfir_pkg::REL_W'(k);
            assign age_r = smfir_pkg::fold_age(x_r, i_slot.pmin);
            assign pair  = smfir_pkg::PAIR_W'(i_win[age_l[IDX_W-1:0]])
                         + smfir_pkg::PAIR_W'(i_win[age_r[IDX_W-1:0]]);
        end

        assign coef      = (LAG_W'(k) <= i_taps) ? i_coef[k] : '0;
        assign n_prod[k] = coef * pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_prod <= n_prod;
            r_meta <= i_slot.meta;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_meta  = r_meta;

endmodule

/* src/smfir_out.sv */
// ----------------------------------------------------------------------------
// smfir_out
// Product sum, round half up, saturate to 16 bits and output register.
// ----------------------------------------------------------------------------
module smfir_out #(
    parameter int MAX_HALF_LENGTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [smfir_pkg::PROD_W-1:0]   i_prod [MAX_HALF_LENGTH],
    input  smfir_pkg::t_meta                      i_meta,
    output logic                                  o_free,
    output logic                                  o_tvalid,
    input  logic                                  i_tready,
    output logic signed [smfir_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                  o_line_end,
    output logic                                  o_burst_end
);

    logic signed [smfir_pkg::ACC_W-1:0]    acc;
    logic signed [smfir_pkg::ACC_W-1:0]    rnd;
    logic signed [smfir_pkg::SAMPLE_W-1:0] n_sample;
    logic                                  r_tvalid;
    logic signed [smfir_pkg::SAMPLE_W-1:0] r_sample;
    smfir_pkg::t_meta                      r_meta;

    assign o_free = !r_tvalid || i_tready;

    always_comb begin
        acc = '0;
        for (int k = 0; k < MAX_HALF_LENGTH; k++) begin
            acc = acc + smfir_pkg::ACC_W'(i_prod[k]);
        end
        rnd = (acc + smfir_pkg::ROUND_HALF) >>> smfir_pkg::FRAC_W;
        if (rnd > smfir_pkg::ACC_W'(smfir_pkg::SAT_MAX)) begin
            n_sample = smfir_pkg::SAT_MAX;
        end else if (rnd < smfir_pkg::ACC_W'(smfir_pkg::SAT_MIN)) begin
            n_sample = smfir_pkg::SAT_MIN;
        end else begin
            n_sample = rnd[smfir_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (o_free) begin
            r_tvalid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_sample <= n_sample;
            r_meta   <= i_meta;
        end
    end

    assign o_tvalid    = r_tvalid;
    assign o_sample    = r_sample;
    assign o_line_end  = r_meta.line_end;
    assign o_burst_end = r_meta.burst_end;

endmodule

/* src/symmetric_fir_mirror_boundary.sv */
// ----------------------------------------------------------------------------
// symmetric_fir_mirror_boundary
// Symmetric FIR line filter, up to seven taps, whole-sample mirror boundary.
// ----------------------------------------------------------------------------
// Samples of a line enter on the s_axis channel, one per transfer; filtered
// samples leave on m_axis, tlast marking the last position of the line and
// tuser[0] the last result caused by one input transfer.
// Output i leaves once sample i+K (K = half_length-1) has arrived; the last
// sample of a line flushes the outputs still pending, up to K+1 of them.
// A result of an input transfer passes the window and sequencer register,
// the product register and the output register. Throughput: one sample
// per cycle in mid-line unless the output stalls; a transfer that causes
// n results holds s_axis_tready low until all of them have issued from
// the single tap-multiply unit, one position per cycle unless stalled.
// Reset clears the line position, the pipeline valids and loads the
// registers with half_length 4, line_length 4096, an identity centre tap.
// When m_axis_tready is low the output register holds; the product stage
// and the sequencer fill behind it, then s_axis_tready falls.
// Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module symmetric_fir_mirror_boundary #(
    parameter int MAX_LINE_LENGTH = 4096,
    parameter int MAX_HALF_LENGTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // [15:0] sample_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [15:0] sample_out
    output logic                              m_axis_tlast,
    output logic [0:0]                        m_axis_tuser,   // [0] burst_end
    input  logic                              i_cfg_we,
    input  logic [smfir_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [smfir_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int WIN   = 2 * MAX_HALF_LENGTH - 1;
    localparam int LAG_W = $clog2(MAX_HALF_LENGTH);

    logic [smfir_pkg::HL_W-1:0]          r_half_length;
    logic [smfir_pkg::LEN_W-1:0]         r_line_length;
    logic signed [smfir_pkg::COEF_W-1:0] r_coef [smfir_pkg::NUM_COEF];

    logic [smfir_pkg::HL_W-1:0] hl_c;
    logic [LAG_W-1:0]           taps;

    logic                                  issue;
    logic                                  mac_free;
    smfir_pkg::t_slot                      slot;
    logic signed [smfir_pkg::SAMPLE_W-1:0] win [WIN];
    logic                                  prod_valid;
    logic signed [smfir_pkg::PROD_W-1:0]   prod [MAX_HALF_LENGTH];
    smfir_pkg::t_meta                      prod_meta;
    logic                                  out_free;
    logic signed [smfir_pkg::SAMPLE_W-1:0] sample_out;
    logic                                  burst_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_length <= smfir_pkg::HL_W'(4);
            r_line_length <= smfir_pkg::LEN_W'(4096);
            r_coef[0]     <= smfir_pkg::COEF_W'(32768);
            r_coef[1]     <= '0;
            r_coef[2]     <= '0;
            r_coef[3]     <= '0;
        end else if (i_cfg_we) begin
            case (smfir_pkg::t_cfg_idx'(i_cfg_idx))
                smfir_pkg::CFG_HALF_LENGTH: r_half_length <= i_cfg_data[smfir_pkg::HL_W-1:0];
                smfir_pkg::CFG_LINE_LENGTH: r_line_length <= i_cfg_data[smfir_pkg::LEN_W-1:0];
                smfir_pkg::CFG_COEF_CENTER: r_coef[0] <= i_cfg_data;
                smfir_pkg::CFG_COEF_ONE:    r_coef[1] <= i_cfg_data;
                smfir_pkg::CFG_COEF_TWO:    r_coef[2] <= i_cfg_data;
                smfir_pkg::CFG_COEF_THREE:  r_coef[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_half_length < smfir_pkg::HL_W'(2)) begin
            hl_c = smfir_pkg::HL_W'(2);
        end else if (r_half_length > smfir_pkg::HL_W'(MAX_HALF_LENGTH)) begin
            hl_c = smfir_pkg::HL_W'(MAX_HALF_LENGTH);
        end else begin
            hl_c = r_half_length;
        end
        taps = LAG_W'(hl_c - smfir_pkg::HL_W'(1));
    end

    smfir_front #(
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
        .MAX_HALF_LENGTH (MAX_HALF_LENGTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_sample      (s_axis_tdata),
        .i_line_length (r_line_length),
        .i_taps        (taps),
        .i_free        (mac_free),
        .o_issue       (issue),
        .o_slot        (slot),
        .o_win         (win)
    );

    smfir_mac #(
        .MAX_HALF_LENGTH (MAX_HALF_LENGTH)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (issue),
        .i_slot      (slot),
        .i_win       (win),
        .i_taps      (taps),
        .i_coef      (r_coef),
        .i_next_free (out_free),
        .o_free      (mac_free),
        .o_valid     (prod_valid),
        .o_prod      (prod),
        .o_meta      (prod_meta)
    );

    smfir_out #(
        .MAX_HALF_LENGTH (MAX_HALF_LENGTH)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (prod_valid),
        .i_prod      (prod),
        .i_meta      (prod_meta),
        .o_free      (out_free),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_sample    (sample_out),
        .o_line_end  (m_axis_tlast),
        .o_burst_end (burst_end)
    );

    assign m_axis_tdata = sample_out;
    assign m_axis_tuser = burst_end;

endmodule

/* tb/smfir_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfir_checker
// Watches the sample, result and register channels of the symmetric FIR
// line filter, predicts every filtered sample with the mirror boundary and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module smfir_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // [15:0] sample_in
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [15:0]                       m_axis_tdata,   // [15:0] sample_out
    input  logic                              m_axis_tlast,
    input  logic [0:0]                        m_axis_tuser,   // [0] burst_end
    input  logic                              i_cfg_we,
    input  logic [smfir_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [smfir_pkg::CFG_W-1:0]       i_cfg_data,
    output int                                o_mismatches,
    output int                                o_outstanding
);

    localparam int LINE_MAX  = 4096;
    localparam int HALF_MAX  = 4;
    localparam int WIN_DEPTH = 2 * HALF_MAX - 1;
    localparam int BURST_MAX = 4;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               line_end;
        logic               burst_end;
    } t_filt;

    logic signed [15:0] win [WIN_DEPTH];
    int                 in_pos;
    int                 out_pos;
    logic [2:0]         half_len;
    logic [12:0]        line_len;
    logic signed [17:0] coef [4];
    t_filt              filtered_q [$];
    int                 mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic int fold(int j, int n);
        int per;
        int m;
        if (n <= 1) return 0;
        per = 2 * n - 2;
        m = (j + 2 * per) % per;
        if (m >= n) m = per - m;
        return m;
    endfunction

    function automatic longint tap_at(int m, int newest);
        int age;
        age = newest - m;
        if (age < 0) age = 0;
        if (age > WIN_DEPTH - 1) age = WIN_DEPTH - 1;
        return longint'(win[age]);
    endfunction

    function automatic logic signed [15:0] filter_at(int i, int n, int taps, int newest);
        longint acc;
        longint r;
        int     k;
        acc = longint'(coef[0]) * tap_at(fold(i, n), newest);
        for (k = 1; k <= taps; k++) begin
            acc += longint'(coef[k]) *
                   (tap_at(fold(i - k, n), newest) + tap_at(fold(i + k, n), newest));
        end
        r = (acc + 64'sd16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    task automatic accept_sample(logic [15:0] sample_in);
        int                 a;
        int                 p;
        int                 n;
        int                 hl;
        int                 taps;
        int                 cnt;
        bit                 last;
        t_filt              r;
        logic signed [15:0] burst [BURST_MAX];
        bit                 ends [BURST_MAX];
        for (a = WIN_DEPTH - 1; a > 0; a--) win[a] = win[a-1];
        win[0] = sample_in;
        p  = in_pos;
        n  = int'(line_len);
        hl = int'(half_len);
        if (n < 1) n = 1;
        if (n > LINE_MAX) n = LINE_MAX;
        if (hl < 2) hl = 2;
        if (hl > HALF_MAX) hl = HALF_MAX;
        taps = hl - 1;
        last = (p + 1 >= n);
        if (last) n = p + 1;
        cnt = 0;
        while (cnt < BURST_MAX && out_pos <= p && (last || out_pos + taps <= p)) begin
            burst[cnt] = filter_at(out_pos, n, taps, p);
            ends[cnt]  = last && (out_pos == p);
            out_pos++;
            cnt++;
        end
        for (a = 0; a < cnt; a++) begin
            r.sample    = burst[a];
            r.line_end  = ends[a];
            r.burst_end = (a == cnt - 1);
            filtered_q.push_back(r);
        end
        if (last) begin
            in_pos  = 0;
            out_pos = 0;
        end else begin
            in_pos = p + 1;
        end
    endtask

    task automatic check_result();
        t_filt want;
        if (filtered_q.size() == 0) begin
            $error("result transfer with nothing expected: sample_out %0d",
                   $signed(m_axis_tdata));
            mismatch_count++;
            return;
        end
        want = filtered_q.pop_front();
        if (m_axis_tdata !== want.sample) begin
            $error("sample_out: expected %0d, got %0d", want.sample, $signed(m_axis_tdata));
            mismatch_count++;
        end
        if (m_axis_tlast !== want.line_end) begin
            $error("line_end: expected %0d, got %0d", want.line_end, m_axis_tlast);
            mismatch_count++;
        end
        if (m_axis_tuser[0] !== want.burst_end) begin
            $error("burst_end: expected %0d, got %0d", want.burst_end, m_axis_tuser[0]);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < WIN_DEPTH; a++) win[a] = '0;
            in_pos   = 0;
            out_pos  = 0;
            half_len = 3'd4;
            line_len = 13'd4096;
            coef[0]  = 18'sd32768;
            coef[1]  = '0;
            coef[2]  = '0;
            coef[3]  = '0;
            filtered_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (s_axis_tvalid && s_axis_tready) accept_sample(s_axis_tdata);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    smfir_pkg::CFG_HALF_LENGTH: half_len = i_cfg_data[2:0];
                    smfir_pkg::CFG_LINE_LENGTH: line_len = i_cfg_data[12:0];
                    smfir_pkg::CFG_COEF_CENTER: coef[0]  = i_cfg_data[17:0];
                    smfir_pkg::CFG_COEF_ONE:    coef[1]  = i_cfg_data[17:0];
                    smfir_pkg::CFG_COEF_TWO:    coef[2]  = i_cfg_data[17:0];
                    smfir_pkg::CFG_COEF_THREE:  coef[3]  = i_cfg_data[17:0];
                    default: ;
                endcase
            end
        end
        o_outstanding <= filtered_q.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sample lines and register settings into the symmetric FIR line
// filter, with random idling on both channels and one long result stall;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 40;
    localparam int SETTLE_CYCLES  = 8;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [15:0]                     m_axis_tdata;
    logic                            m_axis_tlast;
    logic [0:0]                      m_axis_tuser;
    logic                            i_cfg_we      = 1'b0;
    logic [smfir_pkg::CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [smfir_pkg::CFG_W-1:0]     i_cfg_data    = '0;

    int mismatches;
    int outstanding;
    bit tx_idle_en  = 1'b0;
    bit rx_idle_en  = 1'b0;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int rx_gap      = 0;
    int idle_cycles = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    symmetric_fir_mirror_boundary u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    smfir_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // hold off for a long stretch on request, else idle in short bursts
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            rx_gap = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(logic [15:0] sample);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid, wait for every expected result, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(smfir_pkg::t_cfg_idx idx, int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= smfir_pkg::CFG_W'(value);
        @(posedge i_clk);
    endtask

    task automatic configure(int hl, int n, int c0, int c1, int c2, int c3);
        settle();
        cfg_write(smfir_pkg::CFG_HALF_LENGTH, hl);
        cfg_write(smfir_pkg::CFG_LINE_LENGTH, n);
        cfg_write(smfir_pkg::CFG_COEF_CENTER, c0);
        cfg_write(smfir_pkg::CFG_COEF_ONE, c1);
        cfg_write(smfir_pkg::CFG_COEF_TWO, c2);
        cfg_write(smfir_pkg::CFG_COEF_THREE, c3);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 7) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int rand_coef();
        case ($urandom_range(0, 7))
            0:       return 131071;
            1:       return -131072;
            2:       return 0;
            default: return int'($urandom_range(0, 65536)) - 32768;
        endcase
    endfunction

    function automatic int rand_line_length();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(4097, 8191);
            1:       return 0;
            2:       return 4096;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    initial begin
        int sent;
        int phase;
        int burst;
        int hl;
        sent  = 0;
        phase = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        // reset settings: long line, identity centre tap
        send(16'h7FFF);
        send(16'h8000);
        send(16'h0000);
        send(16'hFFFF);
        send(16'h5555);
        // shorten the line mid-way: flush four pending outputs
        configure(4, 1, 32768, 0, 0, 0);
        send(16'hAAAA);
        // clamp half-length down, zero line length, extreme taps
        configure(7, 0, 131071, -131072, 131071, -131072);
        send(16'h7FFF);
        send(16'h8000);
        send(16'h1234);
        // clamp half-length up, line length above the maximum
        configure(0, 8191, -131072, 131071, -131072, 131071);
        send(16'h7FFF);
        send(16'h8000);
        send(16'h7FFF);
        send(16'h8000);
        send(16'h0001);
        configure(2, 2, 16384, 8192, -8192, 4096);
        send(16'h0064);
        send(16'hFF9C);
        send(16'h0003);
        configure(3, 3, 32768, -16384, 8192, 0);
        send(16'h0100);
        send(16'hFE00);
        send(16'h7000);
        send(16'h9000);
        configure(5, 4, 20000, 5000, -3000, 1000);
        send(16'h0F0F);
        send(16'hF0F0);
        send(16'h3C3C);
        send(16'hC3C3);

        while (sent < 75) begin
            tx_idle_en = (sent < 50) && ($urandom_range(0, 3) != 0);
            rx_idle_en <= (sent < 50) && ($urandom_range(0, 3) != 0);
            hl = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 4) : $urandom_range(0, 7);
            configure(hl, rand_line_length(), rand_coef(), rand_coef(), rand_coef(),
                      rand_coef());
            burst = $urandom_range(4, 14);
            if (phase == 2) begin
                tx_idle_en = 1'b0;
                hold_reqs <= hold_reqs + 1;
                burst = 14;
            end
            repeat (burst) send(rand_sample());
            sent += burst;
            phase++;
        end

        settle();
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

/* files.f */
src/smfir_pkg.sv
src/smfir_front.sv
src/smfir_mac.sv
src/smfir_out.sv
src/symmetric_fir_mirror_boundary.sv
tb/smfir_checker.sv
tb/tb_top.sv
